// File: design/vts_pkg.sv
// ----------------------------------------------------------------------------
// vts_pkg: shared types and constants of the token scanner
// Result item layout, result kinds, token codes and the keyword table.
// ----------------------------------------------------------------------------
`default_nettype none

package vts_pkg;

  // Longest keyword that can be recognised; the open word keeps this many bytes.
  localparam int KwMaxLen = 8;
  localparam int KwIdxW   = $clog2(KwMaxLen);
  localparam int KwCount  = 27;

  // Word length counter saturates at its all-ones value.
  localparam int LenW = 4;
  localparam logic [LenW-1:0] LenMax = '1;

  // Result queue depth.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [4:0] CodeIdent   = 5'd0;
  localparam logic [4:0] CodeInteger = 5'd1;
  localparam logic [4:0] CodeFirstKw = 5'd2;

  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChNul   = 8'h00;

  // Keyword text, right aligned: the first character sits in the highest used byte.
  localparam logic [8*KwMaxLen-1:0] KwText [KwCount] = '{
    "argument", "constant", "function", "pointer", "if-goto", "return",
    "local", "label", "static", "call", "goto", "this", "that", "temp",
    "push", "pop", "add", "sub", "not", "neg", "and", "or", "eq", "gt", "lt",
    "reset", "halt"
  };

  localparam logic [LenW-1:0] KwLen [KwCount] = '{
    4'd8, 4'd8, 4'd8, 4'd7, 4'd7, 4'd6, 4'd5, 4'd5, 4'd6, 4'd4, 4'd4, 4'd4,
    4'd4, 4'd4, 4'd4, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2,
    4'd2, 4'd5, 4'd4
  };

  typedef enum logic [1:0] {
    KindText  = 2'd0,
    KindClose = 2'd1,
    KindBad   = 2'd2,
    KindEnd   = 2'd3
  } kind_e;

  typedef logic [KwMaxLen-1:0][7:0] prefix_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic [4:0] code;
    logic       last;
  } result_t;

  // Up to two results produced by one scanned item.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } res_pair_t;

endpackage

`default_nettype wire

// File: design/vts_kw_match.sv
// ----------------------------------------------------------------------------
// vts_kw_match: parallel keyword matcher
// Compares the stored word prefix with every keyword at once and gives the
// token code of the closed word.
// ----------------------------------------------------------------------------
`default_nettype none

module vts_kw_match import vts_pkg::*; (
  input  prefix_t         prefix_i,
  input  logic [LenW-1:0] len_i,
  output logic [4:0]      code_o
);

  always_comb begin
    logic [8*KwMaxLen-1:0] kw_left;
    logic                  hit;
    code_o = CodeIdent;
    // Walk downwards so that the earliest table entry wins.
    for (int k = KwCount - 1; k >= 0; k--) begin
      kw_left = KwText[k] << (8 * (KwMaxLen - int'(KwLen[k])));
      hit     = (len_i == KwLen[k]);
      for (int i = 0; i < KwMaxLen; i++) begin
        if ((i < int'(KwLen[k])) &&
            (prefix_i[i] != kw_left[8*(KwMaxLen-i)-1 -: 8])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        code_o = CodeFirstKw + 5'(k);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/vts_scan_core.sv
// ----------------------------------------------------------------------------
// vts_scan_core: input register and scanner state
// Registers one source item, classifies it against the scan mode and hands
// up to two results to the result queue in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vts_scan_core import vts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_end_i,
  output logic       in_ready_o,
  input  logic       room_i,
  output res_pair_t  push_o
);

  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModeWord    = 3'd1,
    ModeNumber  = 3'd2,
    ModeComment = 3'd3,
    ModeSlash   = 3'd4
  } mode_e;

  logic            in_valid_q;
  logic [7:0]      byte_q;
  logic            end_q;
  mode_e           mode_q, mode_d;
  logic [LenW-1:0] len_q;
  prefix_t         prefix_q;

  logic       advance;
  logic       endf, is_letter, is_digitish, is_wordch, is_blank, is_eol;
  logic [4:0] kw_code;
  logic       fr_v, fr_word;
  result_t    fr_r;
  mode_e      fr_mode;
  logic       v0, v1, add_ch, start_word;
  result_t    r0, r1;

  assign advance    = in_valid_q & room_i;
  assign in_ready_o = ~in_valid_q | room_i;

  vts_kw_match u_kw_match (
    .prefix_i (prefix_q),
    .len_i    (len_q),
    .code_o   (kw_code)
  );

  always_comb begin
    endf        = end_q | (byte_q == ChNul);
    is_letter   = ((byte_q >= 8'h61) && (byte_q <= 8'h7A)) ||
                  ((byte_q >= 8'h41) && (byte_q <= 8'h5A));
    is_digitish = ((byte_q >= 8'h30) && (byte_q <= 8'h39)) || (byte_q == ChMinus);
    is_wordch   = is_letter | is_digitish | (byte_q == ChUnder) | (byte_q == ChDot);
    is_eol      = (byte_q == ChCr) || (byte_q == ChLf);
    is_blank    = is_eol || (byte_q == ChSpace) || (byte_q == ChTab);
  end

  // Handling of a byte that starts afresh from idle.
  always_comb begin
    fr_v    = 1'b0;
    fr_word = 1'b0;
    fr_mode = ModeIdle;
    fr_r    = '{kind: KindText, ch: 8'h00, code: CodeIdent, last: 1'b0};
    priority if (endf) begin
      fr_v      = 1'b1;
      fr_r.kind = KindEnd;
    end else if (byte_q == ChHash) begin
      fr_mode = ModeComment;
    end else if (byte_q == ChSlash) begin
      fr_mode = ModeSlash;
    end else if (is_digitish) begin
      fr_mode = ModeNumber;
      fr_v    = 1'b1;
      fr_r.ch = byte_q;
    end else if (is_letter) begin
      fr_mode = ModeWord;
      fr_word = 1'b1;
      fr_v    = 1'b1;
      fr_r.ch = byte_q;
    end else if (is_blank) begin
      fr_mode = ModeIdle;
    end else begin
      fr_v      = 1'b1;
      fr_r.kind = KindBad;
      fr_r.ch   = byte_q;
    end
  end

  always_comb begin
    mode_d     = mode_q;
    v0         = 1'b0;
    v1         = 1'b0;
    add_ch     = 1'b0;
    start_word = 1'b0;
    r0         = '{kind: KindText, ch: 8'h00, code: CodeIdent, last: 1'b0};
    r1         = fr_r;
    unique case (mode_q)
      ModeWord: begin
        if (!endf && is_wordch) begin
          add_ch = 1'b1;
          v0     = 1'b1;
          r0.ch  = byte_q;
        end else begin
          // The closing byte is then scanned as a fresh byte.
          v0         = 1'b1;
          r0.kind    = KindClose;
          r0.code    = kw_code;
          v1         = fr_v;
          mode_d     = fr_mode;
          start_word = fr_word;
        end
      end
      ModeNumber: begin
        if (!endf && is_digitish) begin
          v0    = 1'b1;
          r0.ch = byte_q;
        end else begin
          // The byte that ends a number is dropped.
          v0      = 1'b1;
          r0.kind = KindClose;
          r0.code = CodeInteger;
          mode_d  = ModeIdle;
          v1      = endf;
          r1      = '{kind: KindEnd, ch: 8'h00, code: CodeIdent, last: 1'b0};
        end
      end
      ModeComment: begin
        if (endf) begin
          mode_d  = ModeIdle;
          v0      = 1'b1;
          r0.kind = KindEnd;
        end else if (is_eol) begin
          mode_d = ModeIdle;
        end
      end
      ModeSlash: begin
        if (!endf && (byte_q == ChSlash)) begin
          mode_d = ModeComment;
        end else begin
          v0         = fr_v;
          r0         = fr_r;
          mode_d     = fr_mode;
          start_word = fr_word;
        end
      end
      default: begin
        v0         = fr_v;
        r0         = fr_r;
        mode_d     = fr_mode;
        start_word = fr_word;
      end
    endcase
    r0.last = v0 & ~v1;
    r1.last = v1;
  end

  assign push_o = '{v0: advance & v0, v1: advance & v1, r0: r0, r1: r1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      mode_q     <= ModeIdle;
      len_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        mode_q <= mode_d;
        if (start_word) begin
          len_q <= LenW'(1);
        end else if (add_ch && (len_q != LenMax)) begin
          len_q <= len_q + LenW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      end_q  <= in_end_i;
    end
    if (advance) begin
      if (start_word) begin
        prefix_q[0] <= byte_q;
      end else if (add_ch && (len_q < LenW'(KwMaxLen))) begin
        prefix_q[len_q[KwIdxW-1:0]] <= byte_q;
      end
    end
  end

  a_word_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeWord) |-> (len_q != '0))
    else $error("open word with zero length");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.v1 |-> (push_o.v0 && (push_o.r0.kind == KindClose)))
    else $error("second result without a closing first result");

  a_bad_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.v0 && (push_o.r0.kind == KindBad)) |=> (mode_q == ModeIdle))
    else $error("bad character did not leave the scanner idle");

endmodule

`default_nettype wire

// File: design/vts_out_queue.sv
// ----------------------------------------------------------------------------
// vts_out_queue: result queue
// Takes up to two results a cycle from the scanner and presents one result
// item a cycle on the output stream while the output side is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module vts_out_queue import vts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_pair_t push_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      ready_i,
  output result_t   head_o
);

  result_t            mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   cnt_q;
  logic               pop;
  logic [QCntW-1:0]   n_push;

  // Room for a full pair of results, whatever the output side does.
  assign room_o  = (cnt_q <= QCntW'(QDepth - 2));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o & ready_i;
  assign n_push  = QCntW'(push_i.v0) + QCntW'(push_i.v1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + n_push - QCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wr_ptr_q + QPtrW'(1)] <= push_i.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.v0 || push_i.v1) |-> room_o)
    else $error("result pushed without room in the queue");

endmodule

`default_nettype wire

// File: design/vm_token_scanner_unit.sv
// A result is offered on the master side once its item has passed the input register and
// the result queue. Throughput: one source item per cycle while each item gives at most one
// result and the master side takes every result. The four-entry result queue sets the rate
// when the master side stalls or an item that closes a token gives two results.
// Reset clears the scan mode, the word length, the input register and the result queue.
// ----------------------------------------------------------------------------
// vm_token_scanner_unit: byte-serial lexer for a stack-VM language
// Echoes the characters of words and numbers, closes them with a token code
// (identifier, integer or keyword), skips blanks and comments, flags bad
// characters and marks the end of input.
// ----------------------------------------------------------------------------
`default_nettype none

module vm_token_scanner_unit import vts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] source_byte
  input  logic        s_axis_tlast_i,   // end_of_input
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] text_char, [12:8] token_code, [15:13] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] result_kind
  output logic        m_axis_tlast_o    // last_of_run
);

  res_pair_t push;
  logic      room;
  result_t   head;

  vts_scan_core u_scan_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_end_i   (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .room_i     (room),
    .push_o     (push)
  );

  vts_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .head_o  (head)
  );

  assign m_axis_tdata_o = {3'b000, head.code, head.ch};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule

`default_nettype wire

// File: tb/vm_token_scanner_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vm_token_scanner_checker: result predictor and scoreboard for the scanner
// Watches both streams of the token scanner. Each accepted source item is run
// through a cycle-free model of the lexer, and the result items that it gives
// are queued. Each accepted result item is checked field by field against the
// oldest queued one.
// ----------------------------------------------------------------------------

module vm_token_scanner_checker import vts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        src_valid_i,
  input  logic        src_ready_i,
  input  logic [7:0]  src_byte_i,     // [7:0] source_byte
  input  logic        src_end_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [15:0] res_data_i,     // [7:0] text_char, [12:8] token_code, [15:13] zero
  input  logic [1:0]  res_kind_i,     // [1:0] result_kind
  input  logic        res_last_i,
  output int          mismatch_count_o,
  output int          outstanding_o
);

  typedef enum logic [2:0] {
    ScanIdle,
    ScanWord,
    ScanNumber,
    ScanComment,
    ScanSlash
  } scan_mode_e;

  scan_mode_e      mode_q;
  logic [7:0]      prefix_q [KwMaxLen];
  logic [LenW-1:0] length_q;

  result_t token_results_q [$];
  result_t step_res [2];
  int      step_n;

  initial begin
    mode_q           = ScanIdle;
    length_q         = '0;
    mismatch_count_o = 0;
    outstanding_o    = 0;
  end

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digitish(input logic [7:0] c);
    return (c >= "0" && c <= "9") || c == ChMinus;
  endfunction

  task automatic note_result(input kind_e kind, input logic [7:0] ch, input logic [4:0] code);
    step_res[step_n].kind = kind;
    step_res[step_n].ch   = ch;
    step_res[step_n].code = code;
    step_res[step_n].last = 1'b0;
    step_n++;
  endtask

  task automatic add_word_char(input logic [7:0] c);
    if (length_q < KwMaxLen) begin
      prefix_q[length_q[KwIdxW-1:0]] = c;
    end
    if (length_q != LenMax) begin
      length_q++;
    end
  endtask

  // Keyword text is stored right aligned, so the first character of a keyword
  // of length n sits in byte n-1.
  function automatic logic [4:0] keyword_code();
    logic [4:0] code;
    logic       hit;
    int         len;
    int         k;
    int         i;
    code = CodeIdent;
    for (k = 0; k < KwCount; k++) begin
      len = KwLen[k];
      if (length_q == len) begin
        hit = 1'b1;
        for (i = 0; i < len; i++) begin
          if (prefix_q[i] != KwText[k][8*(len-1-i) +: 8]) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          code = CodeFirstKw + 5'(k);
        end
      end
    end
    return code;
  endfunction

  task automatic start_fresh(input logic [7:0] c, input logic is_end);
    mode_q = ScanIdle;
    if (is_end) begin
      note_result(KindEnd, 8'h00, 5'd0);
    end else if (c == ChHash) begin
      mode_q = ScanComment;
    end else if (c == ChSlash) begin
      mode_q = ScanSlash;
    end else if (is_digitish(c)) begin
      mode_q = ScanNumber;
      note_result(KindText, c, 5'd0);
    end else if (is_letter(c)) begin
      mode_q   = ScanWord;
      length_q = '0;
      add_word_char(c);
      note_result(KindText, c, 5'd0);
    end else if (!(c == ChSpace || c == ChTab || c == ChCr || c == ChLf)) begin
      note_result(KindBad, c, 5'd0);
    end
  endtask

  task automatic scan_source_byte(input logic [7:0] c, input logic end_flag);
    logic is_end;
    int   i;
    is_end = end_flag || c == ChNul;
    step_n = 0;
    case (mode_q)
      ScanWord: begin
        if (!is_end && (is_letter(c) || is_digitish(c) || c == ChUnder || c == ChDot)) begin
          add_word_char(c);
          note_result(KindText, c, 5'd0);
        end else begin
          // The byte that ends a word is scanned again from idle.
          note_result(KindClose, 8'h00, keyword_code());
          start_fresh(c, is_end);
        end
      end
      ScanNumber: begin
        if (!is_end && is_digitish(c)) begin
          note_result(KindText, c, 5'd0);
        end else begin
          note_result(KindClose, 8'h00, CodeInteger);
          mode_q = ScanIdle;
          if (is_end) begin
            note_result(KindEnd, 8'h00, 5'd0);
          end
        end
      end
      ScanComment: begin
        if (is_end) begin
          mode_q = ScanIdle;
          note_result(KindEnd, 8'h00, 5'd0);
        end else if (c == ChCr || c == ChLf) begin
          mode_q = ScanIdle;
        end
      end
      ScanSlash: begin
        if (!is_end && c == ChSlash) begin
          mode_q = ScanComment;
        end else begin
          start_fresh(c, is_end);
        end
      end
      default: begin
        start_fresh(c, is_end);
      end
    endcase
    if (step_n > 0) begin
      step_res[step_n-1].last = 1'b1;
    end
    for (i = 0; i < step_n; i++) begin
      token_results_q.insert(token_results_q.size(), step_res[i]);
    end
  endtask

  always @(posedge clk_i) begin
    result_t    want;
    logic [4:0] got_code;
    logic [7:0] got_ch;
    logic [2:0] got_pad;
    if (!rst_ni) begin
      mode_q   = ScanIdle;
      length_q = '0;
      token_results_q.delete();
    end else begin
      if (src_valid_i && src_ready_i) begin
        scan_source_byte(src_byte_i, src_end_i);
      end
      if (res_valid_i && res_ready_i) begin
        got_ch   = res_data_i[7:0];
        got_code = res_data_i[12:8];
        got_pad  = res_data_i[15:13];
        if (token_results_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10) begin
            $display("%0t: unexpected result item: kind %0d char %02h code %0d last %0b",
                     $realtime, res_kind_i, got_ch, got_code, res_last_i);
          end
        end else begin
          want = token_results_q.pop_front();
          if (res_kind_i != want.kind || got_ch != want.ch || got_code != want.code ||
              res_last_i != want.last || got_pad != 3'b000) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%0t: expected kind %0d char %02h code %0d last %0b pad 0",
                       $realtime, want.kind, want.ch, want.code, want.last);
              $display("%0t: got      kind %0d char %02h code %0d last %0b pad %0d",
                       $realtime, res_kind_i, got_ch, got_code, res_last_i, got_pad);
            end
          end
        end
      end
    end
    outstanding_o = token_results_q.size();
  end

endmodule

// File: tb/vm_token_scanner_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vm_token_scanner_unit_tb: stream test of the token scanner
// Feeds a short hand-written source, then random tokens, comments, blanks,
// bad bytes, end markers and raw noise, with random gaps and stalls on both
// streams. The checker alongside predicts and compares every result item.
// ----------------------------------------------------------------------------

module vm_token_scanner_unit_tb import vts_pkg::*;;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] source_byte
  logic        s_axis_tlast;    // end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;    // [7:0] text_char, [12:8] token_code, [15:13] zero
  logic [1:0]  m_axis_tuser;    // [1:0] result_kind
  logic        m_axis_tlast;    // last_of_run

  int   mismatch_count;
  int   outstanding;
  int   items_sent;
  logic tx_steady;
  logic rx_steady;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  vm_token_scanner_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  vm_token_scanner_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .src_valid_i      (s_axis_tvalid),
    .src_ready_i      (s_axis_tready),
    .src_byte_i       (s_axis_tdata),
    .src_end_i        (s_axis_tlast),
    .res_valid_i      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .res_data_i       (m_axis_tdata),
    .res_kind_i       (m_axis_tuser),
    .res_last_i       (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChCr;
      default: return ChLf;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25));
  endfunction

  // Offers one item after a random gap and returns once it has been taken.
  task automatic push_item(input logic [7:0] b, input logic eoi);
    int gap;
    if ($urandom_range(0, 63) == 0) begin
      tx_steady = !tx_steady;
    end
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = eoi;
    items_sent++;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic push_fragment();
    string      bad_marks;
    int         pick;
    int         len;
    int         k;
    int         i;
    logic [7:0] c;
    bad_marks = "!$%&()*+,:;<=>?@[]^`{|}~";
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      k   = $urandom_range(0, KwCount - 1);
      len = KwLen[k];
      for (i = 0; i < len; i++) begin
        push_item(KwText[k][8*(len-1-i) +: 8], 1'b0);
      end
    end else if (pick < 45) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      for (i = 0; i < len; i++) begin
        case (i == 0 ? 0 : $urandom_range(0, 5))
          0, 1:    c = pick_letter();
          2:       c = "0" + 8'($urandom_range(0, 9));
          3:       c = ChMinus;
          4:       c = ChUnder;
          default: c = ChDot;
        endcase
        push_item(c, 1'b0);
      end
    end else if (pick < 60) begin
      len = $urandom_range(1, 6);
      for (i = 0; i < len; i++) begin
        c = ($urandom_range(0, 4) == 0) ? ChMinus : "0" + 8'($urandom_range(0, 9));
        push_item(c, 1'b0);
      end
    end else if (pick < 70) begin
      len = $urandom_range(1, 4);
      for (i = 0; i < len; i++) begin
        push_item(pick_blank(), 1'b0);
      end
    end else if (pick < 77) begin
      if ($urandom_range(0, 1)) begin
        push_item(ChHash, 1'b0);
      end else begin
        push_item(ChSlash, 1'b0);
        push_item(ChSlash, 1'b0);
      end
      len = $urandom_range(0, 10);
      for (i = 0; i < len; i++) begin
        push_item(8'($urandom_range(32, 126)), 1'b0);
      end
      push_item($urandom_range(0, 1) ? ChCr : ChLf, 1'b0);
    end else if (pick < 81) begin
      push_item(ChSlash, 1'b0);
    end else if (pick < 87) begin
      if ($urandom_range(0, 1)) begin
        c = 8'($urandom_range(128, 255));
      end else begin
        c = bad_marks[$urandom_range(0, bad_marks.len() - 1)];
      end
      push_item(c, 1'b0);
    end else if (pick < 90) begin
      if ($urandom_range(0, 1)) begin
        push_item(ChNul, 1'b0);
      end else begin
        push_item(8'($urandom_range(0, 255)), 1'b1);
      end
    end else begin
      push_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
    // Tokens are mostly separated by a blank; adjacent ones run together.
    if (pick < 60 && $urandom_range(0, 3) != 0) begin
      push_item(pick_blank(), 1'b0);
    end
  endtask

  // Result side: a random stall before each result item.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    rx_steady     = 1'b0;
    forever begin
      if ($urandom_range(0, 63) == 0) begin
        rx_steady = !rx_steady;
      end
      stall = rx_steady ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    string intro;
    int    i;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    tx_steady     = 1'b0;
    items_sent    = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Keyword, number with a minus, lone slash, word with '_' and '.' closed by
    // a blank, both comment forms, then bad bytes and the two end markers.
    intro = "eq 0-9\t/a_Z.\r#c\n//z\n";
    for (i = 0; i < intro.len(); i++) begin
      push_item(intro[i], 1'b0);
    end
    push_item(8'hFF, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h7F, 1'b0);
    push_item(8'hA5, 1'b1);
    push_item("x", 1'b0);
    push_item(ChNul, 1'b0);
    push_item("7", 1'b0);
    push_item(8'h5A, 1'b1);

    while (items_sent < 1780) begin
      push_fragment();
    end
    push_item(8'h00, 1'b1);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    while (outstanding != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
